### hdl/ramped_motor_command_with_debounce_defines.svh
// Assertion macros for the ramped motor command block.
// Used by ramped_motor_command_with_debounce.sv; expects clk and arst_n in scope.
`ifndef RAMPED_MOTOR_COMMAND_WITH_DEBOUNCE_DEFINES_SVH
`define RAMPED_MOTOR_COMMAND_WITH_DEBOUNCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RMCD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RMCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RMCD_ASSERT_IMPL(label, ante, cons, msg)
`define RMCD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/rmcd_pkg.sv
// Constants and register codes for the ramped motor command block.
// No dependencies; used by ramped_motor_command_with_debounce.sv.
`default_nettype none
package rmcd_pkg;

	localparam int BALL_SENSORS     = 4;
	localparam int POSITION_SENSORS = 5;

	// Configuration register indexes.
	localparam logic [1:0] REG_RAMP_RANGE     = 2'd0;
	localparam logic [1:0] REG_RAMP_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_RAMP_STEP      = 2'd2;
	localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd3;

	// Command mode codes.
	localparam logic [1:0] MODE_STOP = 2'd0;
	localparam logic [1:0] MODE_FWD  = 2'd1;
	localparam logic [1:0] MODE_REV  = 2'd2;
	localparam logic [1:0] MODE_HOLD = 2'd3;

	localparam logic signed [11:0] SPEED_MAX = 12'sd1023;
	localparam logic signed [11:0] SPEED_MIN = -12'sd1023;
	localparam logic [15:0]        TICK_MAX  = 16'hFFFF;

	localparam logic [10:0] RAMP_RANGE_RST     = 11'd64;
	localparam logic [15:0] RAMP_INTERVAL_RST  = 16'd10;
	localparam logic [9:0]  RAMP_STEP_RST      = 10'd16;
	localparam logic [3:0]  DEBOUNCE_TICKS_RST = 4'd5;

endpackage
`default_nettype wire

### hdl/ramped_motor_command_with_debounce.sv
// Ramped motor command driver with ball and position sensor debounce.
// Depends on rmcd_pkg and ramped_motor_command_with_debounce_defines.svh.
//
// One item is one control tick: it carries an optional command pair and the raw sensor
// levels, and yields one result item holding the drive lines, status bytes and lamps. The
// command decode, the speed ramp and the debounce counters update in a single pass and the
// result lands in the output register, so a new item is taken on every cycle in which the
// result register is empty or its item is being taken. Input stall follows output stall
// only while a result is waiting. Configuration is written by index; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`default_nettype none
`include "ramped_motor_command_with_debounce_defines.svh"
module ramped_motor_command_with_debounce (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command_valid,
	input  wire logic [7:0]  command_high,
	input  wire logic [7:0]  command_low,
	input  wire logic [3:0]  ball_inputs,
	input  wire logic [4:0]  position_inputs,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       duty,
	output logic             duty_enable,
	output logic             run_switch,
	output logic             reverse_switch,
	output logic             alarm_switch,
	output logic [4:0]       status_position,
	output logic [7:0]       status_mode,
	output logic [7:0]       status_speed,
	output logic             ball_lamp,
	output logic             position_lamp,
	output logic             motion_lamp
);

	localparam int NB = rmcd_pkg::BALL_SENSORS;
	localparam int NP = rmcd_pkg::POSITION_SENSORS;

	// configuration registers
	logic [10:0] ramp_range_q;
	logic [15:0] ramp_interval_q;
	logic [9:0]  ramp_step_q;
	logic [3:0]  debounce_q;

	// block state
	logic [15:0]        held_cmd_q;
	logic               link_seen_q;
	logic               running_q;
	logic signed [10:0] speed_q;
	logic [1:0]         drive_mode_q;
	logic [15:0]        ramp_ticks_q;
	logic [9:0]         duty_q;
	logic               enable_q;
	logic               run_q;
	logic               rev_q;
	logic               alarm_q;
	logic [9:0]         speed_mag_q;
	logic [4:0]         ball_cnt_q [NB];
	logic [4:0]         pos_cnt_q [NP];
	logic [NB-1:0]      ball_flags_q;
	logic [NP-1:0]      pos_flags_q;
	logic               lamp_ball_q;
	logic               lamp_pos_q;
	logic               out_valid_q;

	logic in_accept;
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// next-state values
	logic [15:0]        held_cmd_n;
	logic               running_n;
	logic signed [10:0] speed_n;
	logic [1:0]         drive_mode_n;
	logic [15:0]        ramp_ticks_n;
	logic [9:0]         duty_n;
	logic               enable_n;
	logic               run_n;
	logic               rev_n;
	logic               alarm_n;
	logic [9:0]         speed_mag_n;
	logic [4:0]         ball_cnt_n [NB];
	logic [4:0]         pos_cnt_n [NP];
	logic [NB-1:0]      ball_flags_n;
	logic [NP-1:0]      pos_flags_n;
	logic               lamp_ball_n;
	logic               lamp_pos_n;

	// command decode and speed ramp
	always_comb begin
		logic [1:0]         mode;
		logic [9:0]         target;
		logic signed [11:0] target_s;
		logic signed [11:0] now_s;
		logic signed [11:0] gap;
		logic signed [11:0] gap_abs;
		logic signed [11:0] next_s;
		logic signed [11:0] step_s;
		logic signed [10:0] neg_speed;
		logic [15:0]        ticks_inc;

		held_cmd_n = command_valid ? {command_high, command_low} : held_cmd_q;
		running_n  = command_valid ? command_high[7] : running_q;

		mode     = held_cmd_n[11:10];
		target   = held_cmd_n[9:0];
		target_s = (mode == rmcd_pkg::MODE_REV) ? -$signed({2'b00, target})
		                                        : $signed({2'b00, target});
		now_s    = {speed_q[10], speed_q};
		gap      = target_s - now_s;
		gap_abs  = gap[11] ? -gap : gap;
		step_s   = $signed({2'b00, ramp_step_q});
		ticks_inc = (ramp_ticks_q == rmcd_pkg::TICK_MAX) ? ramp_ticks_q
		                                                 : ramp_ticks_q + 16'd1;

		ramp_ticks_n = ramp_ticks_q;
		speed_n      = 11'sd0;
		drive_mode_n = rmcd_pkg::MODE_STOP;
		duty_n       = duty_q;
		enable_n     = enable_q;
		run_n        = run_q;
		rev_n        = rev_q;
		alarm_n      = 1'b0;
		next_s       = now_s;
		neg_speed    = 11'sd0;
		speed_mag_n  = 10'd0;

		if (running_n) begin
			if (mode == rmcd_pkg::MODE_FWD || mode == rmcd_pkg::MODE_REV) begin
				ramp_ticks_n = ticks_inc;
				if (gap_abs[10:0] > ramp_range_q) begin
					if (ticks_inc >= ramp_interval_q) begin
						ramp_ticks_n = 16'd0;
						next_s = gap[11] ? now_s - step_s : now_s + step_s;
					end
				end else begin
					next_s = target_s;
				end
				if (next_s > rmcd_pkg::SPEED_MAX) begin
					next_s = rmcd_pkg::SPEED_MAX;
				end else if (next_s < rmcd_pkg::SPEED_MIN) begin
					next_s = rmcd_pkg::SPEED_MIN;
				end
				speed_n = next_s[10:0];
			end
			neg_speed = -speed_n;
			priority if (speed_n > 11'sd0) begin
				speed_mag_n  = speed_n[9:0];
				drive_mode_n = rmcd_pkg::MODE_FWD;
			end else if (speed_n < 11'sd0) begin
				speed_mag_n  = neg_speed[9:0];
				drive_mode_n = rmcd_pkg::MODE_REV;
			end else begin
				drive_mode_n = (mode == rmcd_pkg::MODE_HOLD) ? rmcd_pkg::MODE_STOP : mode;
			end
			if (drive_mode_n == rmcd_pkg::MODE_STOP) begin
				// Hold mode keeps the drive lines as they were.
				if (mode == rmcd_pkg::MODE_STOP) begin
					duty_n   = 10'd0;
					enable_n = 1'b0;
					run_n    = 1'b0;
					rev_n    = 1'b0;
				end
			end else begin
				duty_n   = speed_mag_n;
				enable_n = 1'b1;
				run_n    = 1'b1;
				rev_n    = (drive_mode_n == rmcd_pkg::MODE_REV);
			end
			alarm_n = held_cmd_n[14];
		end else begin
			duty_n   = 10'd0;
			enable_n = 1'b0;
			run_n    = 1'b0;
			rev_n    = 1'b0;
		end
	end

	// sensor debounce
	always_comb begin
		logic [4:0] inc;
		logic [4:0] limit;
		logic       exceed;
		logic       any_ball;

		limit       = {1'b0, debounce_q} + 5'd1;
		any_ball    = 1'b0;
		lamp_ball_n = lamp_ball_q;
		lamp_pos_n  = lamp_pos_q;
		for (int i = 0; i < NB; i++) begin
			inc    = ball_cnt_q[i] + 5'd1;
			exceed = inc > {1'b0, debounce_q};
			if (!ball_inputs[i]) begin
				any_ball        = 1'b1;
				ball_cnt_n[i]   = exceed ? limit : inc;
				ball_flags_n[i] = ball_flags_q[i] | exceed;
				if (exceed) begin
					lamp_ball_n = 1'b1;
				end
			end else begin
				ball_cnt_n[i]   = 5'd0;
				ball_flags_n[i] = 1'b0;
			end
		end
		if (!any_ball) begin
			lamp_ball_n = 1'b0;
		end
		for (int i = 0; i < NP; i++) begin
			inc    = pos_cnt_q[i] + 5'd1;
			exceed = inc > {1'b0, debounce_q};
			if (position_inputs[i]) begin
				pos_cnt_n[i]   = exceed ? limit : inc;
				pos_flags_n[i] = pos_flags_q[i] | exceed;
			end else begin
				pos_cnt_n[i]   = 5'd0;
				pos_flags_n[i] = 1'b0;
			end
		end
		// Only the first position sensor drives its lamp.
		if (!position_inputs[0]) begin
			lamp_pos_n = 1'b0;
		end else if (pos_cnt_q[0] + 5'd1 > {1'b0, debounce_q}) begin
			lamp_pos_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_range_q    <= rmcd_pkg::RAMP_RANGE_RST;
			ramp_interval_q <= rmcd_pkg::RAMP_INTERVAL_RST;
			ramp_step_q     <= rmcd_pkg::RAMP_STEP_RST;
			debounce_q      <= rmcd_pkg::DEBOUNCE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmcd_pkg::REG_RAMP_RANGE:     ramp_range_q    <= cfg_data[10:0];
				rmcd_pkg::REG_RAMP_INTERVAL:  ramp_interval_q <= cfg_data;
				rmcd_pkg::REG_RAMP_STEP:      ramp_step_q     <= cfg_data[9:0];
				rmcd_pkg::REG_DEBOUNCE_TICKS: debounce_q      <= cfg_data[3:0];
				default:                      debounce_q      <= debounce_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			held_cmd_q   <= '0;
			link_seen_q  <= 1'b0;
			running_q    <= 1'b0;
			speed_q      <= '0;
			drive_mode_q <= rmcd_pkg::MODE_STOP;
			ramp_ticks_q <= '0;
			duty_q       <= '0;
			enable_q     <= 1'b0;
			run_q        <= 1'b0;
			rev_q        <= 1'b0;
			alarm_q      <= 1'b0;
			speed_mag_q  <= '0;
			ball_flags_q <= '0;
			pos_flags_q  <= '0;
			lamp_ball_q  <= 1'b0;
			lamp_pos_q   <= 1'b0;
			for (int i = 0; i < NB; i++) begin
				ball_cnt_q[i] <= '0;
			end
			for (int i = 0; i < NP; i++) begin
				pos_cnt_q[i] <= '0;
			end
		end else begin
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				held_cmd_q   <= held_cmd_n;
				link_seen_q  <= link_seen_q | command_valid;
				running_q    <= running_n;
				speed_q      <= speed_n;
				drive_mode_q <= drive_mode_n;
				ramp_ticks_q <= ramp_ticks_n;
				duty_q       <= duty_n;
				enable_q     <= enable_n;
				run_q        <= run_n;
				rev_q        <= rev_n;
				alarm_q      <= alarm_n;
				speed_mag_q  <= speed_mag_n;
				ball_flags_q <= ball_flags_n;
				pos_flags_q  <= pos_flags_n;
				lamp_ball_q  <= lamp_ball_n;
				lamp_pos_q   <= lamp_pos_n;
				ball_cnt_q   <= ball_cnt_n;
				pos_cnt_q    <= pos_cnt_n;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign duty            = duty_q;
	assign duty_enable     = enable_q;
	assign run_switch      = run_q;
	assign reverse_switch  = rev_q;
	assign alarm_switch    = alarm_q;
	assign status_position = pos_flags_q;
	assign status_mode     = {ball_flags_q, drive_mode_q, speed_mag_q[9:8]};
	assign status_speed    = speed_mag_q[7:0];
	assign ball_lamp       = lamp_ball_q;
	assign position_lamp   = lamp_pos_q;
	assign motion_lamp     = (drive_mode_q != rmcd_pkg::MODE_STOP);

	`RMCD_ASSERT_IMPL(a_standby_quiet,
		!running_q && link_seen_q,
		speed_mag_q == 10'd0 && drive_mode_q == rmcd_pkg::MODE_STOP && !enable_q && !alarm_q,
		"standby left drive active")
	`RMCD_ASSERT_IMPL(a_drive_matches_mode,
		drive_mode_q != rmcd_pkg::MODE_STOP,
		enable_q && run_q && duty_q == speed_mag_q &&
			rev_q == (drive_mode_q == rmcd_pkg::MODE_REV),
		"drive lines disagree with drive mode")
	`RMCD_ASSERT_NEXT(a_state_holds_when_idle,
		!in_accept,
		$stable(speed_q) && $stable(ramp_ticks_q) && $stable(ball_flags_q),
		"state changed without an item")
	`RMCD_ASSERT_NEXT(a_standby_keeps_ticks,
		in_accept && !running_n,
		$stable(ramp_ticks_q),
		"standby altered the ramp tick counter")
	`RMCD_ASSERT_IMPL(a_pos_lamp_tracks_flag,
		1'b1,
		lamp_pos_q == pos_flags_q[0],
		"position lamp differs from first flag")

endmodule
`default_nettype wire
